// File: design/sbte_pkg.sv
// ----------------------------------------------------------------------------
// sbte_pkg
// Shared types, constants and helpers for the six-bit text encoder.
// ----------------------------------------------------------------------------
package sbte_pkg;

	localparam logic [6:0]  CHAR_OFFSET = 7'h3c;
	localparam logic [5:0]  UNIT_MASK   = 6'h3f;
	localparam logic [15:0] LIMIT_RESET = 16'hffff;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       last_byte;
	} sbte_in_t;

	typedef struct packed {
		logic        has_char;
		logic [6:0]  out_char;
		logic        end_of_message;
		logic [16:0] total_count;
	} sbte_out_t;

	// result set of one byte: count (0..2) and up to two results in order
	typedef struct packed {
		logic [1:0] n;
		sbte_out_t  r0;
		sbte_out_t  r1;
	} sbte_res_t;

	localparam sbte_out_t EMPTY_RESULT = '{has_char: 1'b0, out_char: 7'd0,
		end_of_message: 1'b0, total_count: 17'd0};

	function automatic sbte_out_t mk_char(input logic [5:0] unit);
		sbte_out_t r;
		r = EMPTY_RESULT;
		r.has_char = 1'b1;
		r.out_char = {1'b0, unit & UNIT_MASK} + CHAR_OFFSET;
		return r;
	endfunction

endpackage

// File: design/sbte_regroup.sv
// ----------------------------------------------------------------------------
// sbte_regroup
// Message state and the byte-to-unit regrouping: turns one byte into its
// set of up to two results and updates leftover bits and character count.
// ----------------------------------------------------------------------------
module sbte_regroup import sbte_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  sbte_in_t    item,
	input  logic [15:0] output_limit,
	input  logic        fire,
	output sbte_res_t   res
);

	logic [5:0]  leftover_bits_q;
	logic [2:0]  leftover_count_q;
	logic [16:0] chars_sent_q;

	logic [2:0]  rc_raw;
	logic [2:0]  rc;
	logic [5:0]  made;
	logic [11:0] shl;
	logic [5:0]  rest;
	logic        under;
	logic [5:0]  lb_n;
	logic [2:0]  lc_n;
	logic [16:0] cs_n;
	logic [16:0] cs_d;

	assign rc_raw = leftover_count_q & 3'd6;
	assign rc     = (rc_raw > 3'd4) ? 3'd4 : rc_raw;
	assign made   = (leftover_bits_q | 6'(item.data_byte >> (3'd2 + rc))) & UNIT_MASK;
	assign shl    = {4'b0, item.data_byte} << (3'd4 - rc);
	assign rest   = shl[5:0];
	assign under  = chars_sent_q < {1'b0, output_limit};

	always_comb begin
		res.n  = 2'd0;
		res.r0 = EMPTY_RESULT;
		res.r1 = EMPTY_RESULT;
		lb_n   = leftover_bits_q;
		lc_n   = leftover_count_q;
		cs_n   = chars_sent_q;
		if (under) begin
			res.r0 = mk_char(made);
			res.n  = 2'd1;
			cs_n   = chars_sent_q + 17'd1;
			if (rc < 3'd4) begin
				lb_n = rest;
				lc_n = rc + 3'd2;
			end else begin
				// group complete; second unit only if a slot is left
				if (cs_n < {1'b0, output_limit}) begin
					res.r1 = mk_char(rest);
					res.n  = 2'd2;
					cs_n   = chars_sent_q + 17'd2;
				end
				lb_n = 6'd0;
				lc_n = 3'd0;
			end
		end
		cs_d = cs_n;
		if (item.last_byte) begin
			// flush pending bits, even past the limit
			if (lc_n != 3'd0) begin
				if (res.n == 2'd0) begin
					res.r0 = mk_char(lb_n);
				end else begin
					res.r1 = mk_char(lb_n);
				end
				res.n = res.n + 2'd1;
				cs_n  = cs_n + 17'd1;
			end
			if (res.n == 2'd0) begin
				res.n = 2'd1;
			end
			if (res.n == 2'd1) begin
				res.r0.end_of_message = 1'b1;
				res.r0.total_count    = cs_n;
			end else begin
				res.r1.end_of_message = 1'b1;
				res.r1.total_count    = cs_n;
			end
			lb_n = 6'd0;
			lc_n = 3'd0;
			cs_d = 17'd0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			leftover_bits_q  <= 6'd0;
			leftover_count_q <= 3'd0;
			chars_sent_q     <= 17'd0;
		end else if (fire) begin
			leftover_bits_q  <= lb_n;
			leftover_count_q <= lc_n;
			chars_sent_q     <= cs_d;
		end
	end

	a_lc_legal: assert property (@(posedge clk) disable iff (!arst_n)
		leftover_count_q == 3'd0 || leftover_count_q == 3'd2 || leftover_count_q == 3'd4)
		else $error("leftover count out of range");

	a_last_clears: assert property (@(posedge clk) disable iff (!arst_n)
		fire && item.last_byte |=> chars_sent_q == 17'd0 && leftover_count_q == 3'd0)
		else $error("message state not cleared after last byte");

endmodule

// File: design/sbte_out_buf.sv
// ----------------------------------------------------------------------------
// sbte_out_buf
// Two-entry result queue: up to two results in per cycle, one out when ready.
// ----------------------------------------------------------------------------
module sbte_out_buf import sbte_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      push,
	input  sbte_res_t res,
	output logic [1:0] space,
	output logic      out_valid,
	input  logic      out_ready,
	output sbte_out_t out_data
);

	sbte_out_t  e0_q;
	sbte_out_t  e1_q;
	logic [1:0] cnt_q;

	logic       pop;
	logic [1:0] cnt_a;
	logic [1:0] push_n;
	sbte_out_t  e0_d;
	sbte_out_t  e1_d;

	assign pop       = (cnt_q != 2'd0) && out_ready;
	assign cnt_a     = cnt_q - {1'b0, pop};
	assign push_n    = push ? res.n : 2'd0;
	assign space     = 2'd2 - cnt_a;
	assign out_valid = cnt_q != 2'd0;
	assign out_data  = e0_q;

	always_comb begin
		case (cnt_a)
			2'd0: begin
				e0_d = res.r0;
				e1_d = res.r1;
			end
			2'd1: begin
				e0_d = pop ? e1_q : e0_q;
				e1_d = res.r0;
			end
			default: begin
				e0_d = e0_q;
				e1_d = e1_q;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 2'd0;
		end else begin
			cnt_q <= cnt_a + push_n;
		end
	end

	always_ff @(posedge clk) begin
		e0_q <= e0_d;
		e1_q <= e1_d;
	end

	a_cnt_max: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= 2'd2)
		else $error("result queue overflow");

endmodule

// File: design/six_bit_text_encoder_core.sv
// ----------------------------------------------------------------------------
// six_bit_text_encoder_core
// Regroups message bytes into 6-bit units sent as characters (unit + 0x3c),
// with an output limit and a flush plus character count on the last byte.
//
//  channel  dir  handshake            payload
//  in       in   in_valid/in_ready    sbte_in_t  (data_byte, last_byte)
//  out      out  out_valid/out_ready  sbte_out_t (has_char .. total_count)
//  cfg      in   cfg_valid/cfg_ready  cfg_data = output_limit, always ready
//
// A byte passes an input register, then the regroup logic writes its
// results into a two-entry result queue, whose head entry drives the
// output. Output is one result per cycle while out_ready is high, so the
// results of a byte go out one after the other. Reset clears message state,
// sets the limit to 65535 and empties the queue. A stalled output backs up
// through the queue into the input register.
// ----------------------------------------------------------------------------
module six_bit_text_encoder_core import sbte_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  sbte_in_t    in_data,
	output logic        out_valid,
	input  logic        out_ready,
	output sbte_out_t   out_data,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [15:0] cfg_data
);

	logic [15:0] output_limit_q;
	logic        v_s1;
	sbte_in_t    item_s1;
	sbte_res_t   res;
	logic [1:0]  space;
	logic        fire;

	assign cfg_ready = 1'b1;
	// the whole result set must fit in the queue after this cycle's pop
	assign fire      = v_s1 && (res.n <= space);
	assign in_ready  = !v_s1 || fire;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			output_limit_q <= LIMIT_RESET;
			v_s1           <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				output_limit_q <= cfg_data;
			end
			if (in_valid && in_ready) begin
				v_s1 <= 1'b1;
			end else if (fire) begin
				v_s1 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			item_s1 <= in_data;
		end
	end

	sbte_regroup u_regroup (
		.clk          (clk),
		.arst_n       (arst_n),
		.item         (item_s1),
		.output_limit (output_limit_q),
		.fire         (fire),
		.res          (res)
	);

	sbte_out_buf u_out_buf (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (fire),
		.res       (res),
		.space     (space),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

	a_last_has_result: assert property (@(posedge clk) disable iff (!arst_n)
		fire && item_s1.last_byte |-> res.n != 2'd0)
		else $error("last byte produced no result");

endmodule

// File: tb/tb_six_bit_text_encoder_core.sv
// ----------------------------------------------------------------------------
// tb_six_bit_text_encoder_core
// Self-checking bench for the six-bit text encoder. A short table of directed
// bytes covers limit zero, limit one, the one-slot-left drop, the flush past
// the limit and the end-of-message count. Random messages follow, in phases
// with different output limits and with random stalls on both channels.
// Every accepted byte is run through a local encoder model, and each result
// transaction is checked field by field against the oldest expected character.
// ----------------------------------------------------------------------------
module tb_six_bit_text_encoder_core;
	import sbte_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int DIR_ROWS     = 22;
	localparam int PHASES       = 12;
	localparam int PHASE_ITEMS  = 128;
	localparam int SETTLE_CYCLES = 8;

	// one directed byte; typed rows carry their own expected results
	typedef struct packed {
		logic        set_limit;
		logic [15:0] limit;
		logic [7:0]  data;
		logic        last;
		logic        typed;
		logic [1:0]  n;
		sbte_out_t   e0;
		sbte_out_t   e1;
	} stim_row_t;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_ready;
	sbte_in_t    in_data;
	logic        out_valid;
	logic        out_ready;
	sbte_out_t   out_data;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [15:0] cfg_data;

	// encoder model state
	logic [15:0] out_limit  = LIMIT_RESET;
	logic [5:0]  spare_bits = '0;
	logic [2:0]  spare_cnt  = '0;
	logic [16:0] sent_cnt   = '0;

	sbte_out_t   expected_chars [$];
	sbte_out_t   want;
	stim_row_t   dir_rows [DIR_ROWS];
	int          mismatches = 0;
	bit          quiet      = 1'b0;

	six_bit_text_encoder_core dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data)
	);

	always begin
		clk = 1'b0;
		#4;
		clk = 1'b1;
		#4;
	end

	function automatic sbte_out_t char_res(input logic [6:0] c, input logic eom,
			input logic [16:0] cnt);
		return {1'b1, c, eom, cnt};
	endfunction

	function automatic sbte_out_t bare_end(input logic [16:0] cnt);
		return {1'b0, 7'd0, 1'b1, cnt};
	endfunction

	function automatic sbte_out_t char_of(input logic [5:0] unit);
		return {1'b1, 7'({1'b0, unit} + CHAR_OFFSET), 1'b0, 17'd0};
	endfunction

	// regroup one byte into characters and update the message state
	function automatic sbte_res_t encode_byte(input logic [7:0] b, input logic last);
		sbte_out_t  r [2];
		int         n;
		logic [2:0] shift;
		logic [7:0] hi;
		logic [7:0] lo;
		sbte_res_t  res;
		n = 0;
		r[0] = '0;
		r[1] = '0;
		if (sent_cnt < {1'b0, out_limit}) begin
			shift = spare_cnt & 3'd6;
			if (shift > 3'd4)
				shift = 3'd4;
			hi = b >> (shift + 3'd2);
			lo = b << (3'd4 - shift);
			r[n] = char_of(spare_bits | hi[5:0]);
			n++;
			sent_cnt++;
			if (shift + 3'd2 < 3'd6) begin
				spare_bits = lo[5:0];
				spare_cnt  = shift + 3'd2;
			end else begin
				// group complete; second unit only if a slot is left
				if (sent_cnt < {1'b0, out_limit}) begin
					r[n] = char_of(lo[5:0]);
					n++;
					sent_cnt++;
				end
				spare_bits = '0;
				spare_cnt  = '0;
			end
		end
		if (last) begin
			// flush goes out even past the limit
			if (spare_cnt != 3'd0) begin
				r[n] = char_of(spare_bits);
				n++;
				sent_cnt++;
			end
			if (n == 0) begin
				r[0] = '0;
				n = 1;
			end
			r[n-1].end_of_message = 1'b1;
			r[n-1].total_count    = sent_cnt;
			spare_bits = '0;
			spare_cnt  = '0;
			sent_cnt   = '0;
		end
		res.n  = 2'(n);
		res.r0 = r[0];
		res.r1 = r[1];
		return res;
	endfunction

	function automatic void note_field(input string name, input int unsigned want_v,
			input int unsigned got_v);
		if (want_v != got_v) begin
			$display("%0t: %s mismatch: expected %0h, actual %0h", $time, name, want_v,
				got_v);
			mismatches++;
		end
	endfunction

	// lower valid, wait for every expected character, then let the pipe settle
	task automatic drain_results();
		in_valid <= 1'b0;
		while (expected_chars.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_limit(input logic [15:0] v);
		drain_results();
		cfg_valid <= 1'b1;
		cfg_data  <= v;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		cfg_valid <= 1'b0;
		out_limit = v;
	endtask

	task automatic sender_gap();
		if (!quiet && $urandom_range(0, 3) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 7)) @(posedge clk);
		end
	endtask

	task automatic send_byte(input logic [7:0] b, input logic last, input logic predict);
		sbte_res_t res;
		in_valid <= 1'b1;
		in_data  <= '{data_byte: b, last_byte: last};
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		res = encode_byte(b, last);
		if (predict) begin
			if (res.n > 0)
				expected_chars.push_back(res.r0);
			if (res.n > 1)
				expected_chars.push_back(res.r1);
		end
	endtask

	// result transaction checker
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			if (expected_chars.size() == 0) begin
				$display("%0t: unexpected result, expected none, actual %h", $time,
					out_data);
				mismatches++;
			end else begin
				want = expected_chars.pop_front();
				note_field("has_char", want.has_char, out_data.has_char);
				note_field("out_char", want.out_char, out_data.out_char);
				note_field("end_of_message", want.end_of_message,
					out_data.end_of_message);
				note_field("total_count", want.total_count, out_data.total_count);
			end
		end
	end

	// receiver back-pressure
	initial begin
		out_ready <= 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (!quiet && $urandom_range(0, 5) == 0) begin
				out_ready <= 1'b0;
				repeat ($urandom_range(1, 7)) @(posedge clk);
			end
			out_ready <= 1'b1;
		end
	end

	initial begin
		#4_000_000;
		$display("FAILED: results differ");
		$finish;
	end

	initial begin
		int          msg_len;
		int          max_len;
		int          counted;
		logic [15:0] lim;

		// all-zero byte as a whole message: one unit, then the two pending bits
		dir_rows[0]  = {1'b0, 16'd0, 8'h00, 1'b1, 1'b1, 2'd2,
			char_res(7'h3c, 1'b0, 17'd0), char_res(7'h3c, 1'b1, 17'd2)};
		dir_rows[1]  = {1'b0, 16'd0, 8'hff, 1'b0, 1'b1, 2'd1,
			char_res(7'h7b, 1'b0, 17'd0), sbte_out_t'('0)};
		dir_rows[2]  = {1'b0, 16'd0, 8'hff, 1'b0, 1'b1, 2'd1,
			char_res(7'h7b, 1'b0, 17'd0), sbte_out_t'('0)};
		dir_rows[3]  = {1'b0, 16'd0, 8'hff, 1'b0, 1'b1, 2'd2,
			char_res(7'h7b, 1'b0, 17'd0), char_res(7'h7b, 1'b0, 17'd0)};
		dir_rows[4]  = {1'b0, 16'd0, 8'h80, 1'b0, 1'b0, 2'd0, 52'd0};
		dir_rows[5]  = {1'b0, 16'd0, 8'h7f, 1'b1, 1'b0, 2'd0, 52'd0};
		dir_rows[6]  = {1'b0, 16'd0, 8'ha5, 1'b1, 1'b0, 2'd0, 52'd0};
		dir_rows[7]  = {1'b0, 16'd0, 8'h5a, 1'b0, 1'b0, 2'd0, 52'd0};
		dir_rows[8]  = {1'b0, 16'd0, 8'hc3, 1'b0, 1'b0, 2'd0, 52'd0};
		dir_rows[9]  = {1'b0, 16'd0, 8'h3c, 1'b1, 1'b0, 2'd0, 52'd0};
		// limit zero: everything ignored, message ends with count 0
		dir_rows[10] = {1'b1, 16'd0, 8'haa, 1'b0, 1'b1, 2'd0, 52'd0};
		dir_rows[11] = {1'b0, 16'd0, 8'h55, 1'b1, 1'b1, 2'd1,
			bare_end(17'd0), sbte_out_t'('0)};
		// limit one: later bytes ignored, pending bits still flushed
		dir_rows[12] = {1'b1, 16'd1, 8'hff, 1'b0, 1'b1, 2'd1,
			char_res(7'h7b, 1'b0, 17'd0), sbte_out_t'('0)};
		dir_rows[13] = {1'b0, 16'd0, 8'h12, 1'b0, 1'b1, 2'd0, 52'd0};
		dir_rows[14] = {1'b0, 16'd0, 8'h34, 1'b1, 1'b1, 2'd1,
			char_res(7'h6c, 1'b1, 17'd2), sbte_out_t'('0)};
		// limit three: third byte completes a group with one slot left
		dir_rows[15] = {1'b1, 16'd3, 8'h01, 1'b0, 1'b0, 2'd0, 52'd0};
		dir_rows[16] = {1'b0, 16'd0, 8'h02, 1'b0, 1'b0, 2'd0, 52'd0};
		dir_rows[17] = {1'b0, 16'd0, 8'h03, 1'b0, 1'b0, 2'd0, 52'd0};
		dir_rows[18] = {1'b0, 16'd0, 8'hff, 1'b1, 1'b1, 2'd1,
			bare_end(17'd3), sbte_out_t'('0)};
		dir_rows[19] = {1'b1, 16'd2, 8'hff, 1'b1, 1'b1, 2'd2,
			char_res(7'h7b, 1'b0, 17'd0), char_res(7'h6c, 1'b1, 17'd2)};
		dir_rows[20] = {1'b1, 16'hffff, 8'h00, 1'b0, 1'b0, 2'd0, 52'd0};
		dir_rows[21] = {1'b0, 16'd0, 8'hff, 1'b1, 1'b0, 2'd0, 52'd0};

		in_valid  <= 1'b0;
		in_data   <= '0;
		cfg_valid <= 1'b0;
		cfg_data  <= '0;
		arst_n    <= 1'b0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_rows[i]) begin
			if (dir_rows[i].set_limit)
				write_limit(dir_rows[i].limit);
			sender_gap();
			send_byte(dir_rows[i].data, dir_rows[i].last, !dir_rows[i].typed);
			if (dir_rows[i].typed) begin
				if (dir_rows[i].n > 0)
					expected_chars.push_back(dir_rows[i].e0);
				if (dir_rows[i].n > 1)
					expected_chars.push_back(dir_rows[i].e1);
			end
		end

		for (int ph = 0; ph < PHASES; ph++) begin
			if (ph == 0 || ph == PHASES - 1)
				lim = 16'hffff;
			else if (ph == 1)
				lim = 16'd0;
			else begin
				case ($urandom_range(0, 4))
					0: lim = 16'($urandom_range(1, 5));
					1: lim = 16'($urandom_range(6, 40));
					2: lim = 16'($urandom);
					3: lim = 16'hffff;
					default: lim = 16'd0;
				endcase
			end
			write_limit(lim);
			// no idling at all in the closing phase
			quiet = (ph == PHASES - 1) || ($urandom_range(0, 3) == 0);
			max_len = (lim < 16'd21) ? int'(lim) + 3 : 24;
			counted = 0;
			while (counted < PHASE_ITEMS) begin
				if (!quiet && $urandom_range(0, 19) == 0)
					drain_results();
				msg_len = $urandom_range(1, max_len);
				if (msg_len > PHASE_ITEMS - counted)
					msg_len = PHASE_ITEMS - counted;
				for (int k = 1; k <= msg_len; k++) begin
					sender_gap();
					send_byte(8'($urandom_range(0, 255)), k == msg_len, 1'b1);
					counted++;
				end
			end
		end

		drain_results();
		if (mismatches == 0 && expected_chars.size() == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

endmodule
